// ===== src/perl_pkg.sv =====
// Package for the per-type event rate limiter.
// Holds opcodes, strategy codes, the per-type state record and helpers.
// No dependencies.
`default_nettype none
package perl_pkg;

	localparam int unsigned TIME_W   = 48;
	localparam int unsigned SPAN_W   = 26;
	localparam int unsigned MS_TO_US = 1000;
	localparam int unsigned QENT_W   = 51;

	typedef enum logic [1:0] {
		OP_EVENT     = 2'd0,
		OP_POP       = 2'd1,
		OP_CLEAR_TYP = 2'd2,
		OP_CLEAR_ALL = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IMMEDIATE = 3'd0,
		ST_DEBOUNCE  = 3'd1,
		ST_THROTTLE  = 3'd2,
		ST_QUEUE     = 3'd3,
		ST_MERGE     = 3'd4,
		ST_COOLDOWN  = 3'd5,
		ST_DROP_A    = 3'd6,
		ST_DROP_B    = 3'd7
	} strat_t;

	typedef enum logic [2:0] {
		CFG_STRATEGY = 3'd0,
		CFG_IVL_LO   = 3'd1,
		CFG_IVL_HI   = 3'd2,
		CFG_WIN_LO   = 3'd3,
		CFG_WIN_HI   = 3'd4,
		CFG_QLIMIT   = 3'd5,
		CFG_TAP      = 3'd6,
		CFG_NONE     = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [15:0] rcv;
		logic [15:0] prc;
		logic [15:0] drp;
		logic [15:0] mrg;
	} stats_t;

	typedef struct packed {
		logic [TIME_W-1:0] emit_time;
		logic [TIME_W-1:0] trig_time;
		logic              pend_valid;
		logic [31:0]       pend_payload;
		logic [15:0]       pend_tally;
		stats_t            stats;
	} type_ent_t;

	typedef struct packed {
		logic [15:0] cnt;
		logic [31:0] payload;
		logic [2:0]  typ;
	} qent_t;

	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		sat_inc = (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic logic reached(input logic [TIME_W-1:0] now,
			input logic [TIME_W-1:0] last, input logic [SPAN_W-1:0] span);
		reached = (now >= last) && ((now - last) >= TIME_W'(span));
	endfunction

endpackage
`default_nettype wire

// ===== src/perl_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module perl_ram #(
	parameter int unsigned W = 8,
	parameter int unsigned D = 2
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] waddr,
	input  wire logic [W-1:0]         wdata,
	input  wire logic [$clog2(D)-1:0] raddr,
	output logic      [W-1:0]         rdata
);
	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== src/per_type_event_rate_limiter.sv =====
// Per-type event rate limiter top level; uses perl_pkg and perl_ram.
// Events, pop and clear-all pass through the exec state, which registers the results and done;
// clear-by-type then walks the queue RAM in alternating read and check states.
// A new command is taken only while idle; busy is high while a command is in flight.
// Reset clears configuration, per-type valid bits and queue pointers at once; RAM
// contents of types never written read as zero. Results cannot be stalled.
`default_nettype none
module per_type_event_rate_limiter #(
	parameter int unsigned TYPE_COUNT  = 8,
	parameter int unsigned QUEUE_DEPTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wen,
	input  wire logic [2:0]  cfg_addr,
	input  wire logic [63:0] cfg_data,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  op,
	input  wire logic [2:0]  event_type,
	input  wire logic [47:0] now_us,
	input  wire logic [31:0] payload,
	input  wire logic [15:0] tap_count_in,
	output logic             done,
	output logic             emitted,
	output logic [2:0]       out_type,
	output logic [31:0]      out_payload,
	output logic [15:0]      out_count,
	output logic [4:0]       queue_level,
	output logic [15:0]      recv_total,
	output logic [15:0]      release_total,
	output logic [15:0]      drop_total,
	output logic [15:0]      merge_total,
	output logic             in_cooldown
);
	import perl_pkg::*;

	localparam int unsigned TW = $clog2(TYPE_COUNT);
	localparam int unsigned QW = $clog2(QUEUE_DEPTH);
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned EW = $bits(type_ent_t);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_EXEC   = 4'b0010,
		S_CLR_RD = 4'b0100,
		S_CLR_CK = 4'b1000
	} state_t;

	function automatic logic [QW-1:0] qwrap(input logic [QW-1:0] a, input logic [CW-1:0] b);
		logic [QW:0] s;
		s = {1'b0, a} + (QW+1)'(b);
		if (s >= (QW+1)'(QUEUE_DEPTH)) begin
			s = s - (QW+1)'(QUEUE_DEPTH);
		end
		qwrap = s[QW-1:0];
	endfunction

	state_t state_q;
	logic [23:0]  strat_map_q;
	logic [127:0] ivl_q, win_q;
	logic [39:0]  qlim_map_q;
	logic [2:0]   tap_q;
	logic [TYPE_COUNT-1:0] tvalid_q;
	logic [QW-1:0] qhead_q;
	logic [CW-1:0] qcount_q, walk_i_q, walk_n_q;

	logic [1:0]        op_s1;
	logic [2:0]        typ_s1;
	logic [TIME_W-1:0] now_s1;
	logic [31:0]       pl_s1;
	logic [15:0]       cnt_s1;
	logic              inr_s1, tap_s1;
	logic [2:0]        strat_s1;
	logic [SPAN_W-1:0] iv_s1, win_s1;
	logic [4:0]        lim_s1;

	logic accept;
	logic in_range;
	logic [4:0] lim_raw;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign in_range = ({1'b0, event_type} < 4'(TYPE_COUNT));
	assign lim_raw = qlim_map_q[5*event_type +: 5];

	// type RAM
	logic            t_we;
	type_ent_t       t_wdata, t_rdata, ent, ent_n;
	logic [EW-1:0]   t_rraw;
	assign t_rdata = type_ent_t'(t_rraw);

	perl_ram #(.W(EW), .D(TYPE_COUNT)) u_type_ram (
		.clk(clk), .we(t_we), .waddr(typ_s1[TW-1:0]), .wdata(t_wdata),
		.raddr(event_type[TW-1:0]), .rdata(t_rraw)
	);

	// queue RAM
	logic          q_we;
	logic [QW-1:0] q_waddr, q_raddr;
	qent_t         q_wdata, q_rdata;
	logic [QENT_W-1:0] q_rraw;
	assign q_rdata = qent_t'(q_rraw);

	perl_ram #(.W(QENT_W), .D(QUEUE_DEPTH)) u_queue_ram (
		.clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
		.raddr(q_raddr), .rdata(q_rraw)
	);

	assign q_raddr = (state_q == S_CLR_RD) ? qwrap(qhead_q, walk_i_q) : qhead_q;

	// evaluate one command
	logic  ok, do_push, do_pop, ev_go;
	qent_t cur_e, out_e;
	logic  cool_n;

	always_comb begin
		ent     = (inr_s1 && tvalid_q[typ_s1[TW-1:0]]) ? t_rdata : '0;
		ent_n   = ent;
		ok      = 1'b0;
		do_push = 1'b0;
		do_pop  = 1'b0;
		cur_e   = '{cnt: cnt_s1, payload: pl_s1, typ: typ_s1};
		out_e   = cur_e;
		ev_go   = (op_s1 == OP_EVENT) && inr_s1;
		if (ev_go) begin
			ent_n.stats.rcv = sat_inc(ent.stats.rcv);
			case (strat_t'(strat_s1))
				ST_IMMEDIATE: ok = 1'b1;
				ST_DEBOUNCE: begin
					if (iv_s1 == '0) begin
						ent_n.pend_valid = 1'b0;
						ok = 1'b1;
					end else begin
						if (ent.pend_valid && reached(now_s1, ent.trig_time, iv_s1)) begin
							out_e = '{cnt: ent.pend_tally, payload: ent.pend_payload,
								typ: typ_s1};
							ok = 1'b1;
						end
						ent_n.pend_valid   = 1'b1;
						ent_n.pend_payload = pl_s1;
						ent_n.pend_tally   = cnt_s1;
						ent_n.trig_time    = now_s1;
					end
				end
				ST_THROTTLE, ST_COOLDOWN: begin
					ok = reached(now_s1, ent.emit_time, iv_s1) ||
						((iv_s1 == '0) && (now_s1 < ent.emit_time) &&
						((ent.emit_time - now_s1) < TIME_W'(MS_TO_US)));
				end
				ST_QUEUE: begin
					if (5'(qcount_q) < lim_s1) begin
						do_push = 1'b1;
						if ((iv_s1 == '0) || reached(now_s1, ent.emit_time, iv_s1)) begin
							do_pop = 1'b1;
							ok = 1'b1;
							if (qcount_q != '0) begin
								out_e = q_rdata;
							end
						end
					end
				end
				ST_MERGE: begin
					if (win_s1 == '0) begin
						ent_n.pend_valid = 1'b0;
						ok = 1'b1;
					end else if (ent.pend_valid && !reached(now_s1, ent.trig_time, win_s1)) begin
						if (tap_s1) begin
							ent_n.pend_tally = ent.pend_tally + 16'd1;
						end
						ent_n.stats.mrg = sat_inc(ent.stats.mrg);
						ent_n.trig_time = now_s1;
					end else if (ent.pend_valid) begin
						out_e = '{cnt: ent.pend_tally, payload: ent.pend_payload,
							typ: typ_s1};
						ent_n.pend_valid = 1'b0;
						ok = 1'b1;
					end else begin
						ent_n.pend_valid   = 1'b1;
						ent_n.pend_payload = pl_s1;
						ent_n.pend_tally   = cnt_s1;
						ent_n.trig_time    = now_s1;
					end
				end
				default: ok = 1'b0;
			endcase
			if (ok) begin
				ent_n.stats.prc = sat_inc(ent.stats.prc);
				ent_n.emit_time = now_s1;
			end else begin
				ent_n.stats.drp = sat_inc(ent.stats.drp);
			end
		end else if (op_s1 == OP_POP) begin
			if (qcount_q != '0) begin
				do_pop = 1'b1;
				ok     = 1'b1;
				out_e  = q_rdata;
			end
		end
		cool_n = inr_s1 && !reached(now_s1, ent_n.emit_time, iv_s1);
	end

	assign t_we    = (state_q == S_EXEC) && ev_go;
	assign t_wdata = ent_n;

	always_comb begin
		q_we    = 1'b0;
		q_waddr = qwrap(qhead_q, qcount_q);
		q_wdata = cur_e;
		if (state_q == S_EXEC) begin
			q_we = do_push;
		end else if ((state_q == S_CLR_CK) && (q_rdata.typ != typ_s1)) begin
			q_we    = 1'b1;
			q_waddr = qwrap(qhead_q, walk_n_q);
			q_wdata = q_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strat_map_q <= '0;
			ivl_q       <= '0;
			win_q       <= '0;
			qlim_map_q  <= '0;
			tap_q       <= '0;
		end else if (cfg_wen) begin
			case (cfg_idx_t'(cfg_addr))
				CFG_STRATEGY: strat_map_q <= cfg_data[23:0];
				CFG_IVL_LO:   ivl_q[63:0] <= cfg_data;
				CFG_IVL_HI:   ivl_q[127:64] <= cfg_data;
				CFG_WIN_LO:   win_q[63:0] <= cfg_data;
				CFG_WIN_HI:   win_q[127:64] <= cfg_data;
				CFG_QLIMIT:   qlim_map_q <= cfg_data[39:0];
				CFG_TAP:      tap_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= op;
			typ_s1   <= event_type;
			now_s1   <= now_us;
			pl_s1    <= payload;
			cnt_s1   <= tap_count_in;
			inr_s1   <= in_range;
			tap_s1   <= (event_type == tap_q);
			strat_s1 <= strat_map_q[3*event_type +: 3];
			iv_s1    <= SPAN_W'(ivl_q[16*event_type +: 16]) * SPAN_W'(MS_TO_US);
			win_s1   <= SPAN_W'(win_q[16*event_type +: 16]) * SPAN_W'(MS_TO_US);
			lim_s1   <= (lim_raw > 5'(QUEUE_DEPTH)) ? 5'(QUEUE_DEPTH) : lim_raw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			tvalid_q <= '0;
			qhead_q  <= '0;
			qcount_q <= '0;
			walk_i_q <= '0;
			walk_n_q <= '0;
			done     <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (t_we) begin
						tvalid_q[typ_s1[TW-1:0]] <= 1'b1;
					end
					if (op_s1 == OP_CLEAR_ALL) begin
						qhead_q  <= '0;
						qcount_q <= '0;
					end else begin
						if (do_pop) begin
							qhead_q <= qwrap(qhead_q, CW'(1));
						end
						qcount_q <= qcount_q + CW'(do_push) - CW'(do_pop);
					end
					if (op_s1 == OP_CLEAR_TYP) begin
						walk_i_q <= '0;
						walk_n_q <= '0;
						state_q  <= S_CLR_RD;
					end else begin
						done    <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_CLR_RD: begin
					if (walk_i_q == qcount_q) begin
						qcount_q <= walk_n_q;
						done     <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_CLR_CK;
					end
				end
				S_CLR_CK: begin
					if (q_rdata.typ != typ_s1) begin
						walk_n_q <= walk_n_q + CW'(1);
					end
					walk_i_q <= walk_i_q + CW'(1);
					state_q  <= S_CLR_RD;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	logic [CW-1:0] level_n;
	always_comb begin
		if (op_s1 == OP_CLEAR_ALL) begin
			level_n = '0;
		end else begin
			level_n = qcount_q + CW'(do_push) - CW'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EXEC) begin
			emitted       <= ok;
			out_type      <= ok ? out_e.typ : 3'd0;
			out_payload   <= ok ? out_e.payload : 32'd0;
			out_count     <= ok ? out_e.cnt : 16'd0;
			queue_level   <= 5'(level_n);
			recv_total    <= ent_n.stats.rcv;
			release_total <= ent_n.stats.prc;
			drop_total    <= ent_n.stats.drp;
			merge_total   <= ent_n.stats.mrg;
			in_cooldown   <= cool_n;
		end else if ((state_q == S_CLR_RD) && (walk_i_q == qcount_q)) begin
			queue_level <= 5'(walk_n_q);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qcount_q <= CW'(QUEUE_DEPTH))
		else $error("queue occupancy above depth");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("busy not raised after transfer");

	a_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLR_CK) |-> (walk_n_q <= walk_i_q) && (walk_i_q < qcount_q))
		else $error("clear walk out of bounds");

endmodule
`default_nettype wire
